FILE: rtl/lcsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// LRU cache slot lookup - shared definitions
// Fixed field widths of the lookup request and its result.
// ---------------------------------------------------------------------------
package lcsl_pkg;

    // Width of a lookup key
    localparam int KEY_W = 64;

    // Width of the slot number carried in a result
    localparam int OUT_IDX_W = 4;

    // tdata width of the result channel (slot number padded to a byte)
    localparam int OUT_DATA_W = 8;

endpackage : lcsl_pkg
`default_nettype wire

FILE: rtl/lcsl_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// LRU cache slot lookup - key match
// Compares the request key against every used slot in parallel and returns
// the lowest matching slot as a one-hot vector.
// ---------------------------------------------------------------------------
module lcsl_match
    import lcsl_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [KEY_W-1:0] i_slot_keys [SLOTS],
    input  wire logic [SLOTS-1:0] i_used,
    output logic                  o_hit,
    output logic [SLOTS-1:0]      o_hit_oh
);

    logic [SLOTS-1:0] match;

    // per-slot comparators, unused slots never match
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match[i] = i_used[i] && (i_slot_keys[i] == i_key);
        end
    end

    // keep the lowest match only (keys are unique, so this is defensive)
    assign o_hit_oh = match & (~match + SLOTS'(1));
    assign o_hit    = |match;

endmodule : lcsl_match
`default_nettype wire

FILE: rtl/lcsl_rank.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// LRU cache slot lookup - age ranks
// Holds the age rank of each slot (0 is newest), finds the eviction victim
// and applies the rank update when a request is retired.
// ---------------------------------------------------------------------------
module lcsl_rank
    import lcsl_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_miss,
    input  wire logic [SLOTS-1:0] i_used,
    input  wire logic [SLOTS-1:0] i_chosen_oh,
    output logic      [SLOTS-1:0] o_victim_oh
);

    localparam int RW = $clog2(SLOTS);
    localparam logic [RW-1:0] OLDEST = RW'(SLOTS - 1);

    logic [RW-1:0] r_rank [SLOTS];
    logic [RW-1:0] n_rank [SLOTS];
    logic [RW-1:0] chosen_rank;

    // victim is the slot holding the oldest rank
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            o_victim_oh[i] = (r_rank[i] == OLDEST);
        end
    end

    // old rank of the chosen slot, one-hot mux
    always_comb begin
        chosen_rank = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (i_chosen_oh[i]) begin
                chosen_rank = chosen_rank | r_rank[i];
            end
        end
    end

    // chosen slot becomes newest; younger used slots age by one.
    // On a miss every other used slot is younger than the chosen one.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            if (i_chosen_oh[i]) begin
                n_rank[i] = '0;
            end else if (i_used[i] && (i_miss || (r_rank[i] < chosen_rank))) begin
                n_rank[i] = r_rank[i] + RW'(1);
            end else begin
                n_rank[i] = r_rank[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_en) begin
            r_rank <= n_rank;
        end
    end

endmodule : lcsl_rank
`default_nettype wire

FILE: rtl/lru_cache_slot_lookup_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// LRU cache slot lookup unit
// Fully associative cache directory with least-recently-used replacement.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel, one 64-bit key per beat in tdata.
//   Each request yields exactly one result on m_axis: tdata carries the slot
//   number (low 4 bits) and tuser the hit flag.
//   A hit makes the slot newest; a miss fills the next free slot in order or,
//   when all slots are used, evicts the oldest slot.
//   A request accepted on s_axis is loaded into the input register; key
//   compare, victim select and rank update then run combinationally into
//   the result register, which drives m_axis.
//   One request per cycle is sustained while m_axis does not stall; the
//   rate is set by the compare and rank update loop.
//   When m_axis stalls, the held result keeps its register and one further
//   request is held in the input register; s_axis_tready drops only when
//   both are full.
//   Reset (synchronous, active low) empties the directory: all slots unused,
//   all ranks zero, no request in flight. No clearing pass is needed.
// ---------------------------------------------------------------------------
module lru_cache_slot_lookup_unit
    import lcsl_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [KEY_W-1:0]      s_axis_tdata,   // [63:0] lookup_key
    // result channel
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [3:0] slot_index, [7:4] zero
    output logic                       m_axis_tuser    // [0] was_hit
);

    localparam int SW = $clog2(SLOTS);
    localparam int XW = (SW > OUT_IDX_W) ? SW : OUT_IDX_W;

    // input register
    logic             r_in_valid;
    logic [KEY_W-1:0] r_in_key;

    // directory state
    logic [KEY_W-1:0] r_keys [SLOTS];
    logic [SLOTS-1:0] r_used;
    logic [SLOTS-1:0] n_used;

    // result register
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [OUT_IDX_W-1:0] r_out_slot;

    logic             advance;
    logic             retire;
    logic             hit;
    logic [SLOTS-1:0] hit_oh;
    logic [SLOTS-1:0] victim_oh;
    logic [SLOTS-1:0] fill_oh;
    logic [SLOTS-1:0] chosen_oh;
    logic [SW-1:0]    chosen_idx;
    logic [XW-1:0]    chosen_ext;

    // handshake: result register frees when empty or taken
    assign advance       = !r_out_valid || m_axis_tready;
    assign retire        = advance && r_in_valid;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_key <= s_axis_tdata;
        end
    end

    // key compare
    lcsl_match #(
        .SLOTS (SLOTS)
    ) u_match (
        .i_key       (r_in_key),
        .i_slot_keys (r_keys),
        .i_used      (r_used),
        .o_hit       (hit),
        .o_hit_oh    (hit_oh)
    );

    // age ranks and victim
    lcsl_rank #(
        .SLOTS (SLOTS)
    ) u_rank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (retire),
        .i_miss      (!hit),
        .i_used      (r_used),
        .i_chosen_oh (chosen_oh),
        .o_victim_oh (victim_oh)
    );

    // next free slot: first unused slot after the used run
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            if (i == 0) begin
                fill_oh[i] = !r_used[i];
            end else begin
                fill_oh[i] = !r_used[i] && r_used[i-1];
            end
        end
    end

    // slot choice: hit, else fill, else evict
    always_comb begin
        if (hit) begin
            chosen_oh = hit_oh;
        end else if (r_used[SLOTS-1]) begin
            chosen_oh = victim_oh;
        end else begin
            chosen_oh = fill_oh;
        end
    end

    // one-hot to binary
    always_comb begin
        chosen_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (chosen_oh[i]) begin
                chosen_idx = chosen_idx | SW'(i);
            end
        end
    end

    assign chosen_ext = XW'(chosen_idx);
    assign n_used     = r_used | chosen_oh;

    // directory update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (retire) begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (retire && !hit && chosen_oh[i]) begin
                r_keys[i] <= r_in_key;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (retire) begin
            r_out_hit  <= hit;
            r_out_slot <= chosen_ext[OUT_IDX_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_slot);
    assign m_axis_tuser  = r_out_hit;

endmodule : lru_cache_slot_lookup_unit
`default_nettype wire
